// File: hw/rtl/otab_pkg.sv
`timescale 1ns / 1ps
package otab_pkg;
	localparam int FRAC_BITS = 16;
	localparam int CORDIC_STEPS = 24;

	localparam logic [2:0] KIND_ROW0 = 3'd0;
	localparam logic [2:0] KIND_ROW1 = 3'd1;
	localparam logic [2:0] KIND_ROW2 = 3'd2;
	localparam logic [2:0] KIND_MIN  = 3'd3;
	localparam logic [2:0] KIND_MAX  = 3'd4;

	localparam logic [1:0] SHAPE_SOLID = 2'd0;
	localparam logic [1:0] SHAPE_DISK  = 2'd1;
	localparam logic [1:0] SHAPE_QUAD  = 2'd2;
	localparam logic [1:0] SHAPE_PARAB = 2'd3;

	localparam logic signed [35:0] Q30_ONE = 36'sd1073741824;
	localparam logic signed [35:0] Q30_PI = 36'sd3373259426;
	localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
	localparam logic signed [35:0] Q30_TWO_PI = 36'sd6746518852;
	localparam logic signed [35:0] Q30_GAIN = 36'sd652032874;
	localparam logic signed [35:0] Q30_CENTI = 36'sd10737418;

	typedef struct packed {
		logic [1:0] shape_kind;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [19:0] angle_x;
		logic signed [19:0] angle_y;
		logic signed [19:0] angle_z;
		logic signed [31:0] scale_x;
		logic signed [31:0] scale_y;
		logic signed [31:0] scale_z;
	} prim_t;

	typedef struct packed {
		logic [2:0] result_kind;
		logic signed [31:0] value_x;
		logic signed [31:0] value_y;
		logic signed [31:0] value_z;
		logic signed [31:0] value_w;
		logic last_result;
	} res_t;

	// arctangent table for the cordic, q30
	function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
		case (i)
			5'd0: return 36'sd843314857;
			5'd1: return 36'sd497837829;
			5'd2: return 36'sd263043837;
			5'd3: return 36'sd133525159;
			5'd4: return 36'sd67021687;
			5'd5: return 36'sd33543516;
			5'd6: return 36'sd16775851;
			5'd7: return 36'sd8388437;
			5'd8: return 36'sd4194283;
			5'd9: return 36'sd2097149;
			5'd10: return 36'sd1048576;
			5'd11: return 36'sd524288;
			5'd12: return 36'sd262144;
			5'd13: return 36'sd131072;
			5'd14: return 36'sd65536;
			5'd15: return 36'sd32768;
			5'd16: return 36'sd16384;
			5'd17: return 36'sd8192;
			5'd18: return 36'sd4096;
			5'd19: return 36'sd2048;
			5'd20: return 36'sd1024;
			5'd21: return 36'sd512;
			5'd22: return 36'sd256;
			5'd23: return 36'sd128;
			5'd24: return 36'sd64;
			5'd25: return 36'sd32;
			5'd26: return 36'sd16;
			5'd27: return 36'sd8;
			5'd28: return 36'sd4;
			5'd29: return 36'sd2;
			5'd30: return 36'sd1;
			default: return 36'sd1;
		endcase
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [95:0] v);
		if (v > 96'sd2147483647) return 32'sh7fffffff;
		if (v < -96'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [95:0] rnd_shr(input logic signed [95:0] v,
			input int unsigned s);
		logic signed [95:0] h;
		h = 96'sd1 <<< (s - 1);
		return (v + h) >>> s;
	endfunction
endpackage

// File: hw/rtl/otab_if.sv
`timescale 1ns / 1ps
interface otab_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/otab_front.sv
`timescale 1ns / 1ps
module otab_front import otab_pkg::*; (
	input logic clk,
	input logic arst_n,
	otab_if.sink in_ch,
	output logic q_valid,
	output prim_t q_data,
	input logic q_pop
);
	// two-entry queue between front and back
	prim_t mem_q [2];
	logic [1:0] cnt_q;
	logic rd_q, wr_q;
	logic push;
	prim_t wdata;

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push = in_ch.valid && in_ch.ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_data = mem_q[rd_q];

	always_comb begin
		wdata = in_ch.data;
		// disk and quad use unit y scale
		if (in_ch.data.shape_kind == SHAPE_DISK || in_ch.data.shape_kind == SHAPE_QUAD)
			wdata.scale_y = 32'sd1 <<< FRAC_BITS;
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

// File: hw/rtl/otab_back.sv
`timescale 1ns / 1ps
module otab_back import otab_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input prim_t q_data,
	output logic q_pop,
	otab_if.source out_ch
);
	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_TRIG  = 7'b0000010,
		S_QUAT  = 7'b0000100,
		S_NORM  = 7'b0001000,
		S_DIV   = 7'b0010000,
		S_MAT   = 7'b0100000,
		S_EMIT  = 7'b1000000
	} state_t;

	state_t state_q;
	prim_t p_q;
	logic [5:0] step_q;
	logic [2:0] ax_q;
	logic signed [35:0] r_q, cx_q, cy_q;
	logic flip_q;
	logic signed [35:0] cs_q [3];
	logic signed [35:0] sn_q [3];
	logic signed [35:0] pp_q [4];
	logic signed [35:0] qv_q [4];
	logic signed [35:0] iq_q [4];
	logic signed [63:0] n_q;
	// shared restoring divider
	logic [63:0] num_q, rem_q, quo_q, den_q;
	logic [1:0] dsel_q;
	logic signed [63:0] inv_q;
	logic signed [63:0] isc_q [3];
	logic signed [35:0] rot_q [3][3];
	logic signed [35:0] irot_q [3][3];
	logic signed [31:0] dot_q [3];
	logic signed [35:0] lm_q [3][3];
	logic signed [35:0] ty0_q [3];
	logic signed [35:0] ty1_q [3];
	res_t res_q [5];
	logic [2:0] oidx_q;
	logic ovalid_q;

	function automatic logic signed [35:0] mq(input logic signed [35:0] a,
			input logic signed [35:0] b);
		return 36'(rnd_shr(96'(a) * 96'(b), 30));
	endfunction

	function automatic void q2m(input logic signed [35:0] q [4],
			output logic signed [35:0] m [3][3]);
		logic signed [35:0] xx, yy, zz, xz, xy, yz, wx, wy, wz;
		xx = mq(q[0], q[0]); yy = mq(q[1], q[1]); zz = mq(q[2], q[2]);
		xz = mq(q[0], q[2]); xy = mq(q[0], q[1]); yz = mq(q[1], q[2]);
		wx = mq(q[3], q[0]); wy = mq(q[3], q[1]); wz = mq(q[3], q[2]);
		m[0][0] = Q30_ONE - 2 * (yy + zz);
		m[0][1] = 2 * (xy + wz);
		m[0][2] = 2 * (xz - wy);
		m[1][0] = 2 * (xy - wz);
		m[1][1] = Q30_ONE - 2 * (xx + zz);
		m[1][2] = 2 * (yz + wx);
		m[2][0] = 2 * (xz + wy);
		m[2][1] = 2 * (yz - wx);
		m[2][2] = Q30_ONE - 2 * (xx + yy);
	endfunction

	logic signed [19:0] ang;
	logic signed [63:0] red;
	logic signed [63:0] sval;
	logic [63:0] rtry;

	always_comb begin
		unique case (ax_q)
			3'd0: ang = p_q.angle_x;
			3'd1: ang = p_q.angle_y;
			default: ang = p_q.angle_z;
		endcase
		// 20-bit angle times 2^13 never exceeds two pi twice, so fold by compare
		red = 64'(ang) <<< (29 - FRAC_BITS);
		if (red >= 64'(Q30_TWO_PI)) red = red - 64'(Q30_TWO_PI);
		else if (red <= -64'(Q30_TWO_PI)) red = red + 64'(Q30_TWO_PI);
		unique case (dsel_q)
			2'd0: sval = 64'(p_q.scale_x);
			2'd1: sval = 64'(p_q.scale_y);
			default: sval = 64'(p_q.scale_z);
		endcase
		rtry = {rem_q[62:0], num_q[63]};
	end

	assign q_pop = (state_q == S_IDLE) && q_valid;
	assign out_ch.valid = ovalid_q;
	assign out_ch.data = res_q[oidx_q];

	always_ff @(posedge clk or negedge arst_n) begin
		logic signed [63:0] rr, sm;
		logic fl;
		logic signed [35:0] ai, mag, tmin, tmax;
		logic signed [95:0] dot, e, t, ax, az;
		logic signed [35:0] m [3][3];
		logic signed [95:0] lo [3];
		logic signed [95:0] hi [3];
		logic signed [35:0] ye [2];
		logic signed [31:0] pv [3];
		if (!arst_n) begin
			state_q <= S_IDLE;
			ovalid_q <= 1'b0;
			oidx_q <= '0;
			step_q <= '0;
			ax_q <= '0;
			dsel_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (q_valid) begin
					p_q <= q_data;
					ax_q <= '0;
					step_q <= '0;
					state_q <= S_TRIG;
				end
				S_TRIG: begin
					// step 0 loads the reduced angle, then one cordic step per cycle
					if (step_q == 6'd0) begin
						rr = red;
						fl = 1'b0;
						if (rr > 64'(Q30_PI)) rr = rr - 64'(Q30_TWO_PI);
						if (rr < -64'(Q30_PI)) rr = rr + 64'(Q30_TWO_PI);
						if (rr > 64'(Q30_HALF_PI)) begin rr = rr - 64'(Q30_PI); fl = 1'b1; end
						else if (rr < -64'(Q30_HALF_PI)) begin
							rr = rr + 64'(Q30_PI); fl = 1'b1;
						end
						flip_q <= fl;
						r_q <= 36'(rr);
						cx_q <= Q30_GAIN;
						cy_q <= '0;
						step_q <= 6'd1;
					end else if (step_q <= 6'(CORDIC_STEPS)) begin
						ai = 36'(step_q - 6'd1);
						if (r_q >= 0) begin
							cx_q <= cx_q - (cy_q >>> ai[5:0]);
							cy_q <= cy_q + (cx_q >>> ai[5:0]);
							r_q <= r_q - atan_q30(5'(step_q - 6'd1));
						end else begin
							cx_q <= cx_q + (cy_q >>> ai[5:0]);
							cy_q <= cy_q - (cx_q >>> ai[5:0]);
							r_q <= r_q + atan_q30(5'(step_q - 6'd1));
						end
						step_q <= step_q + 6'd1;
					end else begin
						cs_q[ax_q[1:0]] <= flip_q ? -cx_q : cx_q;
						sn_q[ax_q[1:0]] <= flip_q ? -cy_q : cy_q;
						step_q <= '0;
						if (ax_q == 3'd2) state_q <= S_QUAT;
						else ax_q <= ax_q + 3'd1;
					end
				end
				S_QUAT: begin
					// pairwise products of the first two axes, then the third axis
					if (step_q == 6'd0) begin
						pp_q[0] <= mq(cs_q[0], cs_q[1]);
						pp_q[1] <= mq(sn_q[0], sn_q[1]);
						pp_q[2] <= mq(sn_q[0], cs_q[1]);
						pp_q[3] <= mq(cs_q[0], sn_q[1]);
						step_q <= 6'd1;
					end else begin
						qv_q[3] <= mq(pp_q[0], cs_q[2]) + mq(pp_q[1], sn_q[2]);
						qv_q[0] <= mq(pp_q[2], cs_q[2]) - mq(pp_q[3], sn_q[2]);
						qv_q[1] <= mq(pp_q[3], cs_q[2]) + mq(pp_q[2], sn_q[2]);
						qv_q[2] <= mq(pp_q[0], sn_q[2]) - mq(pp_q[1], cs_q[2]);
						step_q <= '0;
						state_q <= S_NORM;
					end
				end
				S_NORM: begin
					sm = 64'(mq(qv_q[0], qv_q[0])) + 64'(mq(qv_q[1], qv_q[1]))
						+ 64'(mq(qv_q[2], qv_q[2])) + 64'(mq(qv_q[3], qv_q[3]));
					n_q <= sm;
					num_q <= (64'd1 << 60) + 64'(sm >>> 1);
					den_q <= sm;
					rem_q <= '0;
					quo_q <= '0;
					step_q <= '0;
					dsel_q <= 2'd3;
					state_q <= S_DIV;
				end
				S_DIV: begin
					// one quotient bit per cycle: inverse norm, then three inverse scales
					if (step_q == 6'd63) begin
						step_q <= '0;
						rem_q <= '0;
						quo_q <= '0;
						if (dsel_q == 2'd3) begin
							inv_q <= (n_q > 0) ? 64'({quo_q[62:0], rtry >= den_q})
								: 64'(Q30_ONE);
						end else begin
							t = 96'({quo_q[62:0], rtry >= den_q});
							if (sval == 0) isc_q[dsel_q] <= 64'sd2147483647;
							else isc_q[dsel_q] <= 64'(sat32(sval < 0 ? -t : t));
						end
						if (dsel_q == 2'd2) state_q <= S_MAT;
						else begin
							dsel_q <= (dsel_q == 2'd3) ? 2'd0 : dsel_q + 2'd1;
						end
						// load next dividend from the next scale
						unique case ((dsel_q == 2'd3) ? 2'd0 : dsel_q + 2'd1)
							2'd0: mag = 36'(p_q.scale_x < 0 ? -64'(p_q.scale_x) : 64'(p_q.scale_x));
							2'd1: mag = 36'(p_q.scale_y < 0 ? -64'(p_q.scale_y) : 64'(p_q.scale_y));
							default: mag = 36'(p_q.scale_z < 0 ? -64'(p_q.scale_z) : 64'(p_q.scale_z));
						endcase
						num_q <= (64'd1 << (2 * FRAC_BITS)) + 64'(mag >>> 1);
						den_q <= (mag == 0) ? 64'd1 : 64'(mag);
					end else begin
						if (rtry >= den_q) begin
							rem_q <= rtry - den_q;
							quo_q <= {quo_q[62:0], 1'b1};
						end else begin
							rem_q <= rtry;
							quo_q <= {quo_q[62:0], 1'b0};
						end
						num_q <= {num_q[62:0], 1'b0};
						step_q <= step_q + 6'd1;
					end
				end
				S_MAT: begin
					// forward rotation and conjugate first, inverse rotation next cycle
					if (step_q == 6'd0) begin
						q2m(qv_q, m);
						rot_q <= m;
						iq_q[0] <= mq(-qv_q[0], 36'(inv_q));
						iq_q[1] <= mq(-qv_q[1], 36'(inv_q));
						iq_q[2] <= mq(-qv_q[2], 36'(inv_q));
						iq_q[3] <= mq(qv_q[3], 36'(inv_q));
						step_q <= 6'd1;
					end else begin
						q2m(iq_q, m);
						irot_q <= m;
						state_q <= S_EMIT;
						step_q <= '0;
					end
				end
				S_EMIT: begin
					pv[0] = p_q.pos_x; pv[1] = p_q.pos_y; pv[2] = p_q.pos_z;
					if (step_q == 6'd0) begin
						for (int r = 0; r < 3; r++) begin
							dot = 0;
							for (int c = 0; c < 3; c++)
								dot = dot + 96'(irot_q[c][r]) * (-96'(pv[c]));
							dot_q[r] <= sat32(rnd_shr(dot, 30));
							res_q[r].result_kind <= 3'(r);
							res_q[r].value_x <= sat32(rnd_shr(96'(isc_q[r]) * 96'(irot_q[0][r]), 30));
							res_q[r].value_y <= sat32(rnd_shr(96'(isc_q[r]) * 96'(irot_q[1][r]), 30));
							res_q[r].value_z <= sat32(rnd_shr(96'(isc_q[r]) * 96'(irot_q[2][r]), 30));
							res_q[r].last_result <= 1'b0;
							for (int c = 0; c < 3; c++) begin
								unique case (c)
									0: e = 96'(p_q.scale_x);
									1: e = 96'(p_q.scale_y);
									default: e = 96'(p_q.scale_z);
								endcase
								lm_q[r][c] <= 36'(rnd_shr(e * 96'(rot_q[c][r]), 30));
							end
						end
						step_q <= 6'd1;
					end else if (step_q == 6'd1) begin
						ye[0] = -Q30_ONE; ye[1] = Q30_ONE;
						if (p_q.shape_kind == SHAPE_DISK || p_q.shape_kind == SHAPE_QUAD) begin
							ye[0] = -Q30_CENTI; ye[1] = Q30_CENTI;
						end else if (p_q.shape_kind == SHAPE_PARAB) ye[0] = '0;
						for (int r = 0; r < 3; r++) begin
							res_q[r].value_w <= sat32(rnd_shr(96'(isc_q[r]) * 96'(dot_q[r]),
								FRAC_BITS));
							ty0_q[r] <= 36'(rnd_shr(96'(lm_q[r][1]) * 96'(ye[0]), 30));
							ty1_q[r] <= 36'(rnd_shr(96'(lm_q[r][1]) * 96'(ye[1]), 30));
						end
						step_q <= 6'd2;
					end else if (step_q == 6'd2) begin
						// x and z extents are exactly plus minus one, so each axis adds
						// its own extreme independently
						for (int r = 0; r < 3; r++) begin
							ax = (lm_q[r][0] < 0) ? -96'(lm_q[r][0]) : 96'(lm_q[r][0]);
							az = (lm_q[r][2] < 0) ? -96'(lm_q[r][2]) : 96'(lm_q[r][2]);
							tmin = (ty0_q[r] < ty1_q[r]) ? ty0_q[r] : ty1_q[r];
							tmax = (ty0_q[r] < ty1_q[r]) ? ty1_q[r] : ty0_q[r];
							lo[r] = 96'(pv[r]) - ax + 96'(tmin) - az;
							hi[r] = 96'(pv[r]) + ax + 96'(tmax) + az;
						end
						res_q[3] <= '{KIND_MIN, sat32(lo[0]), sat32(lo[1]), sat32(lo[2]), 32'sd0, 1'b0};
						res_q[4] <= '{KIND_MAX, sat32(hi[0]), sat32(hi[1]), sat32(hi[2]), 32'sd0, 1'b1};
						oidx_q <= '0;
						ovalid_q <= 1'b1;
						step_q <= 6'd3;
					end else if (out_ch.ready && ovalid_q) begin
						if (oidx_q == 3'd4) begin
							ovalid_q <= 1'b0;
							state_q <= S_IDLE;
						end else oidx_q <= oidx_q + 3'd1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: hw/rtl/object_transform_and_bounds.sv
`timescale 1ns / 1ps
// object transform and bounds: each input transaction is one primitive; five output
// transactions follow (three world-to-local rows, box minimum, box maximum with last_result).
// one shared cordic rotates one step per cycle for each of the three half angles; after the
// quaternion and norm steps one restoring divider yields one quotient bit per cycle for the
// inverse norm and the three inverse scales, followed by the matrix and box steps and the pop
// of the next primitive; a stalled result holds the output until it is taken; a two-entry
// queue lets the next primitives be taken while results drain
module object_transform_and_bounds import otab_pkg::*; (
	input logic clk,
	input logic arst_n,
	otab_if.sink in_ch,
	otab_if.source out_ch
);
	logic q_valid, q_pop;
	prim_t q_data;

	otab_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
	);

	otab_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_data(q_data),
		.q_pop(q_pop), .out_ch(out_ch)
	);
endmodule

// File: hw/rtl/otab_checker.sv
`timescale 1ns / 1ps
module otab_checker import otab_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input res_t out_data
);
	a_last_is_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.last_result == (out_data.result_kind == KIND_MAX)))
		else $error("last flag mismatch");
	a_box_w_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.result_kind == KIND_MIN || out_data.result_kind == KIND_MAX)
		|-> out_data.value_w == 32'sd0)
		else $error("box w not zero");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output not held");
endmodule

bind object_transform_and_bounds otab_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_ch.valid),
	.out_ready(out_ch.ready), .out_data(out_ch.data)
);
